// ===== src/pdc_pkg.sv =====
// ---------------------------------------------------------------------------
// pdc_pkg - shared types for the Pauli diagonal coefficient block
// Controller states, datapath command and status groups, register indexes.
// ---------------------------------------------------------------------------
package pdc_pkg;

  // Width of the qubit count register and its reset value
  localparam int unsigned QCNT_W     = 3;
  localparam logic [QCNT_W-1:0] QCNT_RESET = 3'd6;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_QUBITS  = 1'b0,
    CFG_MIN_MAG = 1'b1
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BF_RD,
    ST_BF_WA,
    ST_BF_WB,
    ST_EM_RD,
    ST_EM_EV,
    ST_FLUSH
  } pdc_state_e;

  // Buffer write data source
  typedef enum logic [1:0] {
    WR_SAMPLE,
    WR_SUM,
    WR_DIFF
  } wr_sel_e;

  // Controller to datapath
  typedef struct packed {
    logic    rd_en;
    logic    wr_en;
    wr_sel_e wr_sel;
    logic    latch_diag;
    logic    take_pend;
    logic    push_out;
    logic    push_last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic qualify;
    logic pend_valid;
    logic slot_free;
  } dp_status_t;

endpackage

// ===== src/pdc_in_if.sv =====
// ---------------------------------------------------------------------------
// pdc_in_if - input channel
// One beat carries one diagonal element and its diagonal index.
// ---------------------------------------------------------------------------
interface pdc_in_if #(
  parameter int unsigned MAX_QUBITS   = 6,
  parameter int unsigned SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic [MAX_QUBITS-1:0]          diag_index;
  logic signed [SAMPLE_WIDTH-1:0] element;

  modport source (output valid, output diag_index, output element, input ready);
  modport sink   (input valid, input diag_index, input element, output ready);
endinterface

// ===== src/pdc_out_if.sv =====
// ---------------------------------------------------------------------------
// pdc_out_if - output channel
// One beat carries one Pauli coefficient, its code and the last flag.
// ---------------------------------------------------------------------------
interface pdc_out_if #(
  parameter int unsigned MAX_QUBITS   = 6,
  parameter int unsigned SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] coef_real;
  logic signed [SAMPLE_WIDTH-1:0] coef_imag;
  logic [2*MAX_QUBITS-1:0]        pauli_code;
  logic                           last;

  modport source (output valid, output coef_real, output coef_imag, output pauli_code,
                  output last, input ready);
  modport sink   (input valid, input coef_real, input coef_imag, input pauli_code,
                  input last, output ready);
endinterface

// ===== src/pauli_diagonal_coefficients.sv =====
// Operation: a diagonal of N = 2^n elements loads one beat per cycle; the
// transform runs n stages of N/2 butterflies, each a read, a sum write and a
// difference write on the single buffer write port; emission reads and checks
// each coefficient in turn, stalling while the output slot is held, then flushes
// the last pending one. Reset clears control state, configuration and the
// latched diagonal; the buffer holds no reset value and needs no clearing pass.
// ---------------------------------------------------------------------------
// pauli_diagonal_coefficients - Pauli coefficients of one XOR diagonal
// Loads the diagonal, runs a fast Walsh-Hadamard transform on a shared
// butterfly unit, scales by 1/N, applies the i^popcount phase and emits
// the coefficients that reach the magnitude threshold.
// ---------------------------------------------------------------------------
module pauli_diagonal_coefficients #(
  parameter int unsigned MAX_QUBITS   = 6,
  parameter int unsigned SAMPLE_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SAMPLE_WIDTH-2:0]       cfg_data_i,
  pdc_in_if.sink                        in_i,
  pdc_out_if.source                     out_o
);
  import pdc_pkg::*;

  localparam int unsigned AW = MAX_QUBITS;
  localparam int unsigned QW = $clog2(MAX_QUBITS + 1);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic [QW-1:0] qubits;
  logic [AW-1:0] rd_addr_a, rd_addr_b, wr_addr, idx;

  // Sequencer
  pdc_ctrl #(
    .MAX_QUBITS(MAX_QUBITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_qcnt_i (cfg_data_i[QCNT_W-1:0]),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .qubits_o   (qubits),
    .rd_addr_a_o(rd_addr_a),
    .rd_addr_b_o(rd_addr_b),
    .wr_addr_o  (wr_addr),
    .idx_o      (idx)
  );

  // Buffer, butterfly and coefficient path
  pdc_datapath #(
    .MAX_QUBITS  (MAX_QUBITS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .qubits_i   (qubits),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .wr_addr_i  (wr_addr),
    .idx_i      (idx),
    .diag_i     (in_i.diag_index),
    .element_i  (in_i.element),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_re_o   (out_o.coef_real),
    .out_im_o   (out_o.coef_imag),
    .out_code_o (out_o.pauli_code),
    .out_last_o (out_o.last)
  );

endmodule

// ===== src/pdc_ctrl.sv =====
// ---------------------------------------------------------------------------
// pdc_ctrl - sequencer
// Counts loads, walks the butterfly stages over the shared buffer and steps
// through the coefficients during emission.
// ---------------------------------------------------------------------------
module pdc_ctrl #(
  parameter int unsigned MAX_QUBITS = 6,
  parameter int unsigned AW         = MAX_QUBITS,
  parameter int unsigned QW         = $clog2(MAX_QUBITS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pdc_pkg::QCNT_W-1:0]    cfg_qcnt_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pdc_pkg::dp_status_t           status_i,
  output pdc_pkg::dp_cmd_t              cmd_o,
  output logic [QW-1:0]                 qubits_o,
  output logic [AW-1:0]                 rd_addr_a_o,
  output logic [AW-1:0]                 rd_addr_b_o,
  output logic [AW-1:0]                 wr_addr_o,
  output logic [AW-1:0]                 idx_o
);
  import pdc_pkg::*;

  pdc_state_e        state_q, state_d;
  logic [QCNT_W-1:0] qcnt_q, qcnt_d;
  logic [AW-1:0]     idx_q, idx_d;
  logic [QW-1:0]     stage_q, stage_d;

  logic [QW-1:0]     n_eff;
  logic [AW:0]       len_w;
  logic [AW-1:0]     len_m1;
  logic [AW-1:0]     half_m1;
  logic [AW-1:0]     hbit;
  logic [AW-1:0]     low_mask;
  logic [AW-1:0]     bf_lo;
  logic [AW-1:0]     bf_hi;
  logic              in_acc;
  logic              advance;
  logic              last_stage;

  // Clamp qubit count to the supported range
  always_comb begin
    if (qcnt_q == '0) begin
      n_eff = QW'(1);
    end else if (32'(qcnt_q) > MAX_QUBITS) begin
      n_eff = QW'(MAX_QUBITS);
    end else begin
      n_eff = QW'(qcnt_q);
    end
  end

  assign len_w      = (AW+1)'(1) << n_eff;
  assign len_m1     = AW'(len_w - (AW+1)'(1));
  assign half_m1    = len_m1 >> 1;
  assign last_stage = (stage_q == n_eff - QW'(1));

  // Butterfly pair: insert a zero at the stage bit of the pair counter
  assign hbit     = AW'(1) << stage_q;
  assign low_mask = hbit - AW'(1);
  assign bf_lo    = ((idx_q & ~low_mask) << 1) | (idx_q & low_mask);
  assign bf_hi    = bf_lo | hbit;

  assign in_ready_o = (state_q == ST_LOAD);
  assign in_acc     = in_valid_i && in_ready_o;
  assign advance    = !status_i.qualify || !status_i.pend_valid || status_i.slot_free;

  assign qubits_o    = n_eff;
  assign idx_o       = idx_q;
  assign rd_addr_a_o = (state_q == ST_BF_RD) ? bf_lo : idx_q;
  assign rd_addr_b_o = bf_hi;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc && idx_q == len_m1) state_d = ST_BF_RD;
      end
      ST_BF_RD: state_d = ST_BF_WA;
      ST_BF_WA: state_d = ST_BF_WB;
      ST_BF_WB: begin
        if (idx_q == half_m1 && last_stage) begin
          state_d = ST_EM_RD;
        end else begin
          state_d = ST_BF_RD;
        end
      end
      ST_EM_RD: state_d = ST_EM_EV;
      ST_EM_EV: begin
        if (advance) begin
          state_d = (idx_q == len_m1) ? ST_FLUSH : ST_EM_RD;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pend_valid || status_i.slot_free) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Counters and configuration
  always_comb begin
    idx_d   = idx_q;
    stage_d = stage_q;
    qcnt_d  = qcnt_q;
    unique case (state_q)
      ST_LOAD: begin
        stage_d = '0;
        if (in_acc) idx_d = (idx_q == len_m1) ? '0 : idx_q + AW'(1);
      end
      ST_BF_WB: begin
        if (idx_q == half_m1) begin
          idx_d   = '0;
          stage_d = stage_q + QW'(1);
        end else begin
          idx_d = idx_q + AW'(1);
        end
      end
      ST_EM_EV: begin
        if (advance) idx_d = (idx_q == len_m1) ? '0 : idx_q + AW'(1);
      end
      default: ;
    endcase
    // Drop any partial diagonal on a qubit count write
    if (cfg_we_i && cfg_idx_i == CFG_QUBITS) begin
      qcnt_d = cfg_qcnt_i;
      idx_d  = '0;
    end
  end

  // Command outputs
  always_comb begin
    cmd_o     = '0;
    wr_addr_o = idx_q;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.wr_en      = in_acc;
        cmd_o.wr_sel     = WR_SAMPLE;
        cmd_o.latch_diag = in_acc && idx_q == '0;
      end
      ST_BF_RD: cmd_o.rd_en = 1'b1;
      ST_BF_WA: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_SUM;
        wr_addr_o    = bf_lo;
      end
      ST_BF_WB: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = WR_DIFF;
        wr_addr_o    = bf_hi;
      end
      ST_EM_RD: cmd_o.rd_en = 1'b1;
      ST_EM_EV: begin
        if (status_i.qualify) begin
          if (!status_i.pend_valid) begin
            cmd_o.take_pend = 1'b1;
          end else if (status_i.slot_free) begin
            cmd_o.take_pend = 1'b1;
            cmd_o.push_out  = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (status_i.pend_valid && status_i.slot_free) begin
          cmd_o.push_out  = 1'b1;
          cmd_o.push_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      qcnt_q  <= QCNT_RESET;
      idx_q   <= '0;
      stage_q <= '0;
    end else begin
      state_q <= state_d;
      qcnt_q  <= qcnt_d;
      idx_q   <= idx_d;
      stage_q <= stage_d;
    end
  end

`ifndef SYNTHESIS
  // Butterfly partners differ in exactly the stage bit
  a_bf_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BF_RD |-> $onehot(rd_addr_a_o ^ rd_addr_b_o))
    else $error("butterfly pair addresses do not differ in one bit");

  // Stage counter stays within the active qubit count during the transform
  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BF_RD || state_q == ST_BF_WA || state_q == ST_BF_WB)
      |-> stage_q < n_eff)
    else $error("butterfly stage out of range");

  // Difference goes back to the upper address read in ST_BF_RD, before ST_BF_WA
  a_diff_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BF_WB |-> wr_addr_o == $past(rd_addr_b_o, 2))
    else $error("butterfly difference written to wrong address");
`endif

endmodule

// ===== src/pdc_datapath.sv =====
// ---------------------------------------------------------------------------
// pdc_datapath - transform buffer and coefficient path
// Holds the sample buffer, the shared butterfly unit, scaling, phase,
// threshold, the pending coefficient and the output register.
// ---------------------------------------------------------------------------
module pdc_datapath #(
  parameter int unsigned MAX_QUBITS   = 6,
  parameter int unsigned SAMPLE_WIDTH = 24,
  parameter int unsigned AW           = MAX_QUBITS,
  parameter int unsigned QW           = $clog2(MAX_QUBITS + 1),
  parameter int unsigned BW           = SAMPLE_WIDTH + MAX_QUBITS,
  parameter int unsigned CW           = 2 * MAX_QUBITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [SAMPLE_WIDTH-2:0]        cfg_data_i,
  input  pdc_pkg::dp_cmd_t               cmd_i,
  output pdc_pkg::dp_status_t            status_o,
  input  logic [QW-1:0]                  qubits_i,
  input  logic [AW-1:0]                  rd_addr_a_i,
  input  logic [AW-1:0]                  rd_addr_b_i,
  input  logic [AW-1:0]                  wr_addr_i,
  input  logic [AW-1:0]                  idx_i,
  input  logic [MAX_QUBITS-1:0]          diag_i,
  input  logic signed [SAMPLE_WIDTH-1:0] element_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_re_o,
  output logic signed [SAMPLE_WIDTH-1:0] out_im_o,
  output logic [CW-1:0]                  out_code_o,
  output logic                           out_last_o
);
  import pdc_pkg::*;

  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned SW    = SAMPLE_WIDTH;
  localparam logic signed [BW-1:0] SMAX_B = {{(BW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [BW-1:0] SMIN_B = {{(BW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SMAX   = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN   = {1'b1, {(SW-1){1'b0}}};

  logic signed [BW-1:0] mem [DEPTH];
  logic signed [BW-1:0] rd_a_q, rd_b_q;
  logic signed [BW-1:0] diff_q;
  logic signed [BW-1:0] wr_data;

  logic [SW-2:0]        min_mag_q;
  logic [AW-1:0]        diag_q;
  logic [AW:0]          len_w;
  logic [AW-1:0]        diag_mask;

  logic signed [BW-1:0] scaled;
  logic signed [SW-1:0] v;
  logic [SW-1:0]        mag;
  logic signed [SW-1:0] v_neg;
  logic signed [SW-1:0] v_ph;
  logic [1:0]           phase;
  logic [AW-1:0]        kmask;
  logic signed [SW-1:0] new_re, new_im;
  logic [CW-1:0]        new_code;

  logic                 pend_valid_q;
  logic signed [SW-1:0] pend_re_q, pend_im_q;
  logic [CW-1:0]        pend_code_q;
  logic                 out_valid_q;
  logic signed [SW-1:0] out_re_q, out_im_q;
  logic [CW-1:0]        out_code_q;
  logic                 out_last_q;
  logic                 slot_free;

  // Select buffer write data
  always_comb begin
    case (cmd_i.wr_sel)
      WR_SUM:  wr_data = rd_a_q + rd_b_q;
      WR_DIFF: wr_data = diff_q;
      default: wr_data = {{MAX_QUBITS{element_i[SW-1]}}, element_i};
    endcase
  end

  // Buffer: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[wr_addr_i] <= wr_data;
    if (cmd_i.rd_en) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  // Hold the butterfly difference for the second write
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && cmd_i.wr_sel == WR_SUM) diff_q <= rd_a_q - rd_b_q;
  end

  assign len_w     = (AW+1)'(1) << qubits_i;
  assign diag_mask = AW'(len_w - (AW+1)'(1));

  // Scale by 1/N with floor, then saturate to sample width
  assign scaled = rd_a_q >>> qubits_i;
  always_comb begin
    if (scaled > SMAX_B) begin
      v = SMAX;
    end else if (scaled < SMIN_B) begin
      v = SMIN;
    end else begin
      v = SW'(scaled);
    end
  end

  assign mag   = v[SW-1] ? SW'(-v) : SW'(v);
  assign v_neg = (v == SMIN) ? SMAX : -v;

  // Phase exponent: popcount(k & s) mod 4
  assign kmask = diag_q & idx_i;
  always_comb begin
    phase = '0;
    for (int b = 0; b < AW; b++) begin
      phase = phase + {1'b0, kmask[b]};
    end
  end

  assign v_ph   = phase[1] ? v_neg : v;
  assign new_re = phase[0] ? '0 : v_ph;
  assign new_im = phase[0] ? v_ph : '0;

  // Interleave s and k bits into Pauli digits
  always_comb begin
    for (int b = 0; b < AW; b++) begin
      new_code[2*b]   = idx_i[b];
      new_code[2*b+1] = diag_q[b];
    end
  end

  assign slot_free = !out_valid_q || out_ready_i;

  assign status_o.qualify    = (mag >= {1'b0, min_mag_q});
  assign status_o.pend_valid = pend_valid_q;
  assign status_o.slot_free  = slot_free;

  // Configuration and diagonal latch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mag_q <= (SW-1)'(1);
      diag_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_MIN_MAG) min_mag_q <= cfg_data_i;
      if (cmd_i.latch_diag) diag_q <= diag_i & diag_mask;
    end
  end

  // Pending coefficient and output beat: control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cmd_i.take_pend) begin
        pend_valid_q <= 1'b1;
      end else if (cmd_i.push_out) begin
        pend_valid_q <= 1'b0;
      end
      if (cmd_i.push_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Pending coefficient and output beat: payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pend) begin
      pend_re_q   <= new_re;
      pend_im_q   <= new_im;
      pend_code_q <= new_code;
    end
    if (cmd_i.push_out) begin
      out_re_q   <= pend_re_q;
      out_im_q   <= pend_im_q;
      out_code_q <= pend_code_q;
      out_last_q <= cmd_i.push_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign out_code_o  = out_code_q;
  assign out_last_o  = out_last_q;

`ifndef SYNTHESIS
  // Never overwrite a pending coefficient without moving it out
  a_pend_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_pend && pend_valid_q |-> cmd_i.push_out)
    else $error("pending coefficient overwritten");

  // Only push into a free output slot, and only from a valid pending entry
  a_push_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push_out |-> slot_free && pend_valid_q)
    else $error("output beat pushed into occupied slot or from empty pending");

  // Hold the output beat while it waits for ready
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=>
      out_valid_q && $stable({out_re_q, out_im_q, out_code_q, out_last_q}))
    else $error("output beat changed while waiting");
`endif

endmodule
